/* rtl/keyword_tokenizer_top_macros.svh */
// Assertion macros shared by the keyword tokenizer RTL.
// Each macro checks on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef KEYWORD_TOKENIZER_TOP_MACROS_SVH
`define KEYWORD_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTH
// General property check.
`define KWT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("keyword tokenizer check failed");
// Condition that must never hold.
`define KWT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("keyword tokenizer forbidden condition");
`else
`define KWT_ASSERT(lbl, prop)
`define KWT_ASSERT_NEVER(lbl, cond)
`endif

`endif

/* rtl/kwt_pkg.sv */
// Package for the keyword tokenizer: token codes, keyword and operator tables,
// result and queue types. No dependencies.
`timescale 1ns / 1ps

package kwt_pkg;

  // Field widths and table sizes.
  localparam int unsigned FIELD_WIDTH = 16;
  localparam int unsigned NUM_KW      = 14;
  localparam int unsigned NUM_OPS     = 14;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Token kind codes.
  localparam logic [4:0] KIND_IDENT   = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_KW_BASE = 5'd2;
  localparam logic [4:0] KIND_OP_BASE = 5'd16;
  localparam logic [4:0] KIND_END     = 5'd30;

  // Token class codes.
  localparam logic CLASS_WORD = 1'b0;
  localparam logic CLASS_OP   = 1'b1;

  // Character codes used by the classifier.
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_CR         = 8'h0D;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_e;

  // Keyword spellings, right-justified in a 9-character field.
  localparam logic [71:0] KW_TEXT [NUM_KW] = '{
    72'("const"), 72'("do"), 72'("else"), 72'("false"), 72'("for"), 72'("if"),
    72'("in"), 72'("interface"), 72'("mut"), 72'("return"), 72'("struct"),
    72'("switch"), 72'("true"), 72'("while")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd5, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd2, 4'd9, 4'd3, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5
  };

  // Operator characters in kind order.
  localparam logic [7:0] OP_CHARS [NUM_OPS] = '{
    "+", "-", "*", "/", "=", "!", "?", ":", "(", ")", "[", "]", ".", ","
  };

  typedef struct packed {
    logic [4:0]             token_kind;
    logic                   token_class;
    logic [FIELD_WIDTH-1:0] start_offset;
    logic [FIELD_WIDTH-1:0] token_length;
    logic                   last_of_run;
  } result_t;

  // Results pushed into the queue by one item, in output order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Character of a keyword at a given position; zero past its end.
  function automatic logic [7:0] kw_char(input int unsigned kw, input logic [3:0] pos);
    logic [71:0] text;
    logic [3:0]  len;
    logic [3:0]  back;
    text = KW_TEXT[kw];
    len  = KW_LEN[kw];
    back = (pos < len) ? (len - 4'd1 - pos) : 4'd0;
    kw_char = (pos < len) ? text[{back, 3'b000} +: 8] : 8'h00;
  endfunction

endpackage

/* rtl/kwt_if.sv */
// Handshake channel interfaces for the keyword tokenizer: text input and token output.
// Depends on kwt_pkg for the field width.
`timescale 1ns / 1ps

interface kwt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface kwt_out_if;
  logic                           valid;
  logic                           ready;
  logic [4:0]                     token_kind;
  logic                           token_class;
  logic [kwt_pkg::FIELD_WIDTH-1:0] start_offset;
  logic [kwt_pkg::FIELD_WIDTH-1:0] token_length;
  logic                           last_of_run;

  modport source (output valid, output token_kind, output token_class,
                  output start_offset, output token_length, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input token_class,
                input start_offset, input token_length, input last_of_run,
                output ready);
endinterface

/* rtl/keyword_tokenizer_top.sv */
// Keyword tokenizer: one text byte per cycle in while the token queue has room, identifier, number, keyword,
// operator and end tokens out in source order.
// A token passes through the input register and then the queue before it is offered.
// Throughput: one byte per cycle; a byte that causes two tokens pushes both into the queue,
// and the four-entry token queue decides when input stalls behind a slow consumer.
// Reset: rst_ni clears scanner state and the queue at once; no clearing pass is needed.
`timescale 1ns / 1ps

module keyword_tokenizer_top #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kwt_in_if.sink    in_i,
  kwt_out_if.source out_o
);

  kwt_pkg::push_t push;
  logic           space_ok;

  // Scanner with its input register.
  kwt_lexer #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .space_ok_i(space_ok),
    .push_o    (push)
  );

  // Result queue feeding the output channel.
  kwt_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .space_ok_o(space_ok),
    .out_o     (out_o)
  );

endmodule

/* rtl/kwt_lexer.sv */
// Input register and scanner state of the keyword tokenizer; classifies one byte per cycle while the queue has room
// and pushes up to two tokens. Depends on kwt_pkg, kwt_if and the assertion macros.
`timescale 1ns / 1ps
`include "keyword_tokenizer_top_macros.svh"

module kwt_lexer #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  kwt_in_if.sink               in_i,
  input  logic                 space_ok_i,
  output kwt_pkg::push_t       push_o
);

  localparam int unsigned PW = POSITION_WIDTH;

  // Input register.
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       eot_q;
  logic       advance;

  // Scanner state.
  kwt_pkg::mode_e              mode_q, mode_d;
  logic [PW-1:0]               begin_q, begin_d;
  logic [PW-1:0]               pos_q, pos_d;
  logic [PW-1:0]               run_q, run_d;
  logic [kwt_pkg::NUM_KW-1:0]  cand_q, cand_d;

  // Classification.
  logic                        is_letter, is_digit, is_space, is_uscore;
  logic                        op_hit;
  logic [4:0]                  op_kind;
  logic [kwt_pkg::NUM_KW-1:0]  keep_cand, first_cand;
  logic                        flush_valid, cont;
  kwt_pkg::result_t            flush_res, op_res, end_res;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    sat_inc = (v == {PW{1'b1}}) ? v : v + 1'b1;
  endfunction

  assign advance    = in_valid_q && space_ok_i;
  assign in_i.ready = !in_valid_q || space_ok_i;

  // Input register: takes a new transaction whenever it is empty or the current one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ch_q  <= in_i.char_byte;
      eot_q <= in_i.end_of_text;
    end
  end

  // Byte classes.
  always_comb begin
    is_letter = ((ch_q >= "a") && (ch_q <= "z")) || ((ch_q >= "A") && (ch_q <= "Z"));
    is_digit  = (ch_q >= "0") && (ch_q <= "9");
    is_space  = (ch_q == kwt_pkg::CHAR_SPACE) ||
                ((ch_q >= kwt_pkg::CHAR_TAB) && (ch_q <= kwt_pkg::CHAR_CR));
    is_uscore = (ch_q == kwt_pkg::CHAR_UNDERSCORE);
    op_hit    = 1'b0;
    op_kind   = kwt_pkg::KIND_OP_BASE;
    for (int i = 0; i < kwt_pkg::NUM_OPS; i++) begin
      if (ch_q == kwt_pkg::OP_CHARS[i]) begin
        op_hit  = 1'b1;
        op_kind = kwt_pkg::KIND_OP_BASE + 5'(i);
      end
    end
  end

  // Keyword candidate narrowing and the candidates opened by a leading letter.
  always_comb begin
    for (int i = 0; i < kwt_pkg::NUM_KW; i++) begin
      keep_cand[i]  = cand_q[i] && (run_q < PW'(kwt_pkg::KW_LEN[i])) &&
                      (kwt_pkg::kw_char(i, run_q[3:0]) == ch_q);
      first_cand[i] = (kwt_pkg::kw_char(i, 4'd0) == ch_q);
    end
  end

  // Pending token, operator token and end token.
  always_comb begin
    flush_valid              = (mode_q == kwt_pkg::MODE_IDENT) ||
                               (mode_q == kwt_pkg::MODE_NUMBER);
    flush_res.token_kind     = (mode_q == kwt_pkg::MODE_NUMBER) ? kwt_pkg::KIND_NUMBER
                                                                : kwt_pkg::KIND_IDENT;
    if (mode_q == kwt_pkg::MODE_IDENT) begin
      for (int i = 0; i < kwt_pkg::NUM_KW; i++) begin
        if (cand_q[i] && (run_q == PW'(kwt_pkg::KW_LEN[i]))) begin
          flush_res.token_kind = kwt_pkg::KIND_KW_BASE + 5'(i);
        end
      end
    end
    flush_res.token_class    = kwt_pkg::CLASS_WORD;
    flush_res.start_offset   = kwt_pkg::FIELD_WIDTH'(begin_q);
    flush_res.token_length   = kwt_pkg::FIELD_WIDTH'(run_q);
    flush_res.last_of_run    = 1'b0;

    op_res.token_kind        = op_kind;
    op_res.token_class       = kwt_pkg::CLASS_OP;
    op_res.start_offset      = kwt_pkg::FIELD_WIDTH'(pos_q);
    op_res.token_length      = kwt_pkg::FIELD_WIDTH'(1);
    op_res.last_of_run       = 1'b1;

    end_res.token_kind       = kwt_pkg::KIND_END;
    end_res.token_class      = kwt_pkg::CLASS_WORD;
    end_res.start_offset     = kwt_pkg::FIELD_WIDTH'(pos_q);
    end_res.token_length     = '0;
    end_res.last_of_run      = 1'b1;

    cont = ((mode_q == kwt_pkg::MODE_IDENT) && (is_letter || is_digit || is_uscore)) ||
           ((mode_q == kwt_pkg::MODE_NUMBER) && is_digit);
  end

  // Next state and pushed results.
  always_comb begin
    mode_d        = mode_q;
    begin_d       = begin_q;
    pos_d         = pos_q;
    run_d         = run_q;
    cand_d        = cand_q;
    push_o.count  = 2'd0;
    push_o.first  = flush_res;
    push_o.second = op_res;
    if (advance) begin
      if (eot_q) begin
        // Terminator: flush, emit the end token and return to the reset state.
        if (flush_valid) begin
          push_o.count  = 2'd2;
          push_o.second = end_res;
        end else begin
          push_o.count = 2'd1;
          push_o.first = end_res;
        end
        mode_d  = kwt_pkg::MODE_IDLE;
        begin_d = '0;
        pos_d   = '0;
        run_d   = '0;
        cand_d  = '0;
      end else if (cont) begin
        if (mode_q == kwt_pkg::MODE_IDENT) begin
          cand_d = keep_cand;
        end
        run_d = sat_inc(run_q);
        pos_d = sat_inc(pos_q);
      end else begin
        // Token boundary: the pending token ends; a letter or digit opens a new one, an operator gets a token.
        mode_d = kwt_pkg::MODE_IDLE;
        cand_d = '0;
        if (is_letter) begin
          mode_d  = kwt_pkg::MODE_IDENT;
          begin_d = pos_q;
          run_d   = PW'(1);
          cand_d  = first_cand;
        end else if (is_digit) begin
          mode_d  = kwt_pkg::MODE_NUMBER;
          begin_d = pos_q;
          run_d   = PW'(1);
        end
        pos_d = sat_inc(pos_q);
        if (!is_letter && !is_digit && !is_space && op_hit) begin
          if (flush_valid) begin
            push_o.count = 2'd2;
          end else begin
            push_o.count = 2'd1;
            push_o.first = op_res;
          end
        end else if (flush_valid) begin
          push_o.count             = 2'd1;
          push_o.first.last_of_run = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= kwt_pkg::MODE_IDLE;
      begin_q <= '0;
      pos_q   <= '0;
      run_q   <= '0;
      cand_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
      cand_q  <= cand_d;
    end
  end

  // Keyword candidates only live inside an identifier.
  `KWT_ASSERT(a_cand_in_ident, (cand_q != '0) |-> (mode_q == kwt_pkg::MODE_IDENT))
  // A terminator leaves the scanner at position zero and idle.
  `KWT_ASSERT(a_eot_resets, (advance && eot_q) |=> (pos_q == '0) && (mode_q == kwt_pkg::MODE_IDLE))
  // Nothing is pushed without an item moving on.
  `KWT_ASSERT_NEVER(a_push_no_item, (push_o.count != 2'd0) && !advance)

endmodule

/* rtl/kwt_queue.sv */
// Four-entry token queue of the keyword tokenizer: takes up to two tokens a cycle while
// two entries are free, hands out one. Depends on kwt_pkg, kwt_if and the assertion macros.
`timescale 1ns / 1ps
`include "keyword_tokenizer_top_macros.svh"

module kwt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kwt_pkg::push_t push_i,
  output logic           space_ok_o,
  kwt_out_if.source      out_o
);

  kwt_pkg::result_t                entries_q [kwt_pkg::QUEUE_DEPTH];
  logic [kwt_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [kwt_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [kwt_pkg::QPTR_W-1:0]      wr_ptr_nx;
  logic [kwt_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                            pop;
  kwt_pkg::result_t                head;

  // Room for the two tokens one item may cause.
  assign space_ok_o = (count_q <= kwt_pkg::QCNT_W'(kwt_pkg::QUEUE_DEPTH - 2));
  assign wr_ptr_nx  = wr_ptr_q + 1'b1;
  assign pop        = out_o.valid && out_o.ready;
  assign head       = entries_q[rd_ptr_q];

  // Output side of the transaction.
  assign out_o.valid        = (count_q != '0);
  assign out_o.token_kind   = head.token_kind;
  assign out_o.token_class  = head.token_class;
  assign out_o.start_offset = head.start_offset;
  assign out_o.token_length = head.token_length;
  assign out_o.last_of_run  = head.last_of_run;

  // Pointer and fill count updates.
  always_comb begin
    rd_ptr_d = rd_ptr_q + kwt_pkg::QPTR_W'(pop);
    wr_ptr_d = wr_ptr_q + kwt_pkg::QPTR_W'(push_i.count);
    count_d  = count_q + kwt_pkg::QCNT_W'(push_i.count) - kwt_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // Token storage.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < kwt_pkg::QUEUE_DEPTH; i++) begin
      if ((push_i.count != 2'd0) && (wr_ptr_q == kwt_pkg::QPTR_W'(i))) begin
        entries_q[i] <= push_i.first;
      end
      if ((push_i.count == 2'd2) && (wr_ptr_nx == kwt_pkg::QPTR_W'(i))) begin
        entries_q[i] <= push_i.second;
      end
    end
  end

  `KWT_ASSERT_NEVER(a_overflow, count_q > kwt_pkg::QCNT_W'(kwt_pkg::QUEUE_DEPTH))
  `KWT_ASSERT(a_push_has_room, (push_i.count != 2'd0) |-> space_ok_o)
  `KWT_ASSERT(a_fill_tracks, pop |=> (count_q == $past(count_q) + kwt_pkg::QCNT_W'($past(push_i.count)) - 3'd1))

endmodule
